### hw/rtl/fezp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fezp_pkg
// Shared widths, constants and controller/datapath interface types for the
// frame energy, zero-crossing and peak block.
// ----------------------------------------------------------------------------
package fezp_pkg;

  localparam int RAW_W             = 32;
  localparam int SAMPLE_LSB        = 14;
  localparam int SAMPLE_W          = 16;
  localparam int LEN_W             = 11;
  localparam int MEAN_W            = 31;
  localparam int RATE_W            = 16;
  localparam int PEAK_W            = 16;
  localparam int SQ_W              = 31;
  localparam int FRAME_LEN_RESET   = 1024;
  localparam int MAX_FRAME_DEFAULT = 1024;

  typedef struct packed {
    logic start;
    logic step;
    logic out_load;
  } fezp_cmd_t;

  typedef struct packed {
    logic last_at_acc;
    logic last_in_flight;
    logic step_last;
    logic out_free;
  } fezp_status_t;

endpackage

### hw/rtl/fezp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fezp_ctrl
// Frame-end sequencer: starts the divider, counts it through its steps and
// hands the quotients to the output register.
// ----------------------------------------------------------------------------
module fezp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  fezp_pkg::fezp_status_t st,
  output fezp_pkg::fezp_cmd_t    cmd,
  output logic                   in_stall
);
  import fezp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    cmd.start    = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (st.last_at_acc) begin
          cmd.start  = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (st.step_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE) || st.last_in_flight;

endmodule

### hw/rtl/fezp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fezp_datapath
// Sample decode, square pipeline, frame accumulators, shared radix-2
// divider for energy and crossing rate, and the output register.
// ----------------------------------------------------------------------------
module fezp_datapath #(
  parameter int MAX_FRAME = fezp_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [fezp_pkg::LEN_W-1:0]    cfg_data,
  input  logic                          in_accept,
  input  logic signed [fezp_pkg::RAW_W-1:0] raw_word,
  input  fezp_pkg::fezp_cmd_t           cmd,
  output fezp_pkg::fezp_status_t        st,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [fezp_pkg::MEAN_W-1:0]   mean_energy,
  output logic [fezp_pkg::RATE_W-1:0]   crossing_rate,
  output logic [fezp_pkg::PEAK_W-1:0]   peak_level
);
  import fezp_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int ESUM_W = 30 + CNT_W;
  localparam int CMP_W  = (LEN_W > CNT_W) ? LEN_W : CNT_W;
  localparam int STEP_W = $clog2(ESUM_W);

  // configuration
  logic [LEN_W-1:0] frame_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= LEN_W'(FRAME_LEN_RESET);
    end else if (cfg_valid) begin
      frame_len <= cfg_data;
    end
  end

  logic [CMP_W-1:0] eff_len;

  always_comb begin
    if (frame_len == '0) begin
      eff_len = CMP_W'(1);
    end else if (CMP_W'(frame_len) > CMP_W'(MAX_FRAME)) begin
      eff_len = CMP_W'(MAX_FRAME);
    end else begin
      eff_len = CMP_W'(frame_len);
    end
  end

  // sample decode and per-frame counters
  logic [SAMPLE_W-1:0] bits;
  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [CNT_W-1:0]    sample_count;
  logic [CNT_W-1:0]    count_inc;
  logic [CNT_W-1:0]    crossing_count;
  logic [CNT_W-1:0]    cross_next;
  logic                previous_negative;
  logic [PEAK_W-1:0]   peak_so_far;
  logic [PEAK_W-1:0]   peak_next;
  logic                last;

  assign bits      = raw_word[SAMPLE_LSB +: SAMPLE_W];
  assign neg       = bits[SAMPLE_W-1];
  assign mag       = neg ? (~bits + SAMPLE_W'(1)) : bits;
  assign count_inc = sample_count + CNT_W'(1);
  assign last      = CMP_W'(count_inc) >= eff_len;
  assign peak_next = (mag > peak_so_far) ? mag : peak_so_far;
  assign cross_next = crossing_count +
                      CNT_W'((sample_count != '0) && (neg != previous_negative));

  logic [CNT_W-1:0]  hold_cross;
  logic [PEAK_W-1:0] hold_peak;
  logic [CNT_W-1:0]  hold_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count      <= '0;
      crossing_count    <= '0;
      previous_negative <= 1'b0;
      peak_so_far       <= '0;
    end else if (in_accept) begin
      if (last) begin
        sample_count      <= '0;
        crossing_count    <= '0;
        previous_negative <= 1'b0;
        peak_so_far       <= '0;
      end else begin
        sample_count      <= count_inc;
        crossing_count    <= cross_next;
        previous_negative <= neg;
        peak_so_far       <= peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last) begin
      hold_cross <= cross_next;
      hold_peak  <= peak_next;
      hold_n     <= count_inc;
    end
  end

  // square pipeline
  logic                  s1_valid;
  logic                  s1_last;
  logic [SAMPLE_W-1:0]   s1_mag;
  logic                  s2_valid;
  logic                  s2_last;
  logic [SQ_W-1:0]       s2_sq;
  logic [2*SAMPLE_W-1:0] prod;

  assign prod = s1_mag * s1_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s2_valid <= 1'b0;
      s2_last  <= 1'b0;
    end else begin
      s1_valid <= in_accept;
      s1_last  <= in_accept && last;
      s2_valid <= s1_valid;
      s2_last  <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_mag <= mag;
    s2_sq  <= prod[SQ_W-1:0];
  end

  // energy accumulator
  logic [ESUM_W-1:0] energy_sum;
  logic [ESUM_W-1:0] sum_new;

  assign sum_new = energy_sum + ESUM_W'(s2_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum <= '0;
    end else if (s2_valid) begin
      energy_sum <= s2_last ? '0 : sum_new;
    end
  end

  // restoring divider, one quotient bit per step for both dividends
  logic [ESUM_W-1:0] div_a;
  logic [ESUM_W-1:0] div_b;
  logic [CNT_W-1:0]  rem_a;
  logic [CNT_W-1:0]  rem_b;
  logic [CNT_W-1:0]  div_n;
  logic [STEP_W-1:0] step_cnt;
  logic [CNT_W:0]    trial_a;
  logic [CNT_W:0]    trial_b;
  logic [CNT_W:0]    diff_a;
  logic [CNT_W:0]    diff_b;
  logic              qa;
  logic              qb;

  assign trial_a = {rem_a, div_a[ESUM_W-1]};
  assign trial_b = {rem_b, div_b[ESUM_W-1]};
  assign diff_a  = trial_a - {1'b0, div_n};
  assign diff_b  = trial_b - {1'b0, div_n};
  assign qa      = trial_a >= {1'b0, div_n};
  assign qb      = trial_b >= {1'b0, div_n};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_a    <= sum_new;
      div_b    <= ESUM_W'({hold_cross, {RATE_W{1'b0}}});
      rem_a    <= '0;
      rem_b    <= '0;
      div_n    <= hold_n;
      step_cnt <= STEP_W'(ESUM_W - 1);
    end else if (cmd.step) begin
      div_a    <= {div_a[ESUM_W-2:0], qa};
      div_b    <= {div_b[ESUM_W-2:0], qb};
      rem_a    <= qa ? diff_a[CNT_W-1:0] : trial_a[CNT_W-1:0];
      rem_b    <= qb ? diff_b[CNT_W-1:0] : trial_b[CNT_W-1:0];
      step_cnt <= step_cnt - STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_energy   <= div_a[MEAN_W-1:0];
      crossing_rate <= div_b[RATE_W-1:0];
      peak_level    <= hold_peak;
    end
  end

  assign st.last_at_acc    = s2_valid && s2_last;
  assign st.last_in_flight = (s1_valid && s1_last) || (s2_valid && s2_last);
  assign st.step_last      = step_cnt == '0;
  assign st.out_free       = !out_valid || !out_stall;

endmodule

### hw/rtl/frame_energy_zcr_peak_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_energy_zcr_peak_top
// Short-time energy, zero-crossing rate and peak level of audio frames.
// ----------------------------------------------------------------------------
// Takes one 32-bit microphone word per cycle while not stalled (sample = bits
// 29..14) and, after every frame_len samples (clamped to 1..MAX_FRAME), delivers one item with
// floor(sum of squares / n), floor(crossings * 65536 / n) and the peak |sample|.
// Within a frame an item is taken every cycle. The item that closes a frame is
// followed by a stall of the input through two square/accumulate stages, a
// start step, then a shared restoring divider producing one quotient bit per
// cycle for both results, and a wait until the output register is free. A
// finished result waits in the output register while the next frame streams in.
module frame_energy_zcr_peak_top #(
  parameter int MAX_FRAME = fezp_pkg::MAX_FRAME_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fezp_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fezp_pkg::RAW_W-1:0] raw_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fezp_pkg::MEAN_W-1:0]       mean_energy,
  output logic [fezp_pkg::RATE_W-1:0]       crossing_rate,
  output logic [fezp_pkg::PEAK_W-1:0]       peak_level
);
  import fezp_pkg::*;

  fezp_cmd_t    cmd;
  fezp_status_t st;
  logic         in_accept;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  fezp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  fezp_datapath #(
    .MAX_FRAME (MAX_FRAME)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .raw_word      (raw_word),
    .cmd           (cmd),
    .st            (st),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .mean_energy   (mean_energy),
    .crossing_rate (crossing_rate),
    .peak_level    (peak_level)
  );

  // frame end in the pipeline blocks new items
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    st.last_in_flight |-> in_stall)
    else $error("item accepted while a frame end is in flight");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.step, cmd.out_load}))
    else $error("controller issued overlapping commands");

  a_start_step: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> cmd.step)
    else $error("divider not stepped after start");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("output overwritten while held");

endmodule

### sim/frame_energy_zcr_peak_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_energy_zcr_peak_top_test
// Self-checking bench for the frame energy, zero-crossing and peak block.
// ----------------------------------------------------------------------------
// Microphone words are queued per phase and sent through a stall handshake by
// a clocked driver. A clocked monitor folds every accepted word into a frame
// model and checks each delivered frame result against the oldest prediction.
// Phases cover frame lengths 0, 1, 1024 and 2047 plus several small ones, and
// length changes in the middle of a frame, including a long frame of full
// scale samples cut short by a change.
// Both sides idle at random; once the receiver holds off long enough for the
// block to back up into its input.
// ----------------------------------------------------------------------------
module frame_energy_zcr_peak_top_test;
  import fezp_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_LEN       = MAX_FRAME_DEFAULT;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [RATE_W-1:0] rate;
    logic [PEAK_W-1:0] peak;
  } frame_stats_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [LEN_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [RAW_W-1:0] raw_word = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [MEAN_W-1:0]       mean_energy;
  logic [RATE_W-1:0]       crossing_rate;
  logic [PEAK_W-1:0]       peak_level;

  frame_energy_zcr_peak_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_word      (raw_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mean_energy   (mean_energy),
    .crossing_rate (crossing_rate),
    .peak_level    (peak_level)
  );

  always #4 clk = ~clk;

  // frame model state
  logic [LEN_W-1:0] frame_len_cfg;
  logic [63:0]      energy_acc;
  int unsigned      cross_acc;
  logic             prev_neg;
  int unsigned      peak_acc;
  int unsigned      count_acc;

  logic [RAW_W-1:0] pending_words[$];
  frame_stats_t     expected_frames[$];

  logic in_taken = 1'b0;
  bit   send_gaps = 1'b1;
  bit   recv_gaps = 1'b1;
  int   idle_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   cycle_count = 0;
  int   errors = 0;
  int   frames_checked = 0;
  int   words_taken = 0;
  int   len_writes = 0;

  task automatic fold_word(input logic [RAW_W-1:0] word);
    logic [15:0]  smp;
    logic         neg;
    logic [16:0]  mag;
    int unsigned  n_eff;
    frame_stats_t r;
    smp = word[29:14];
    neg = smp[15];
    mag = neg ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
    energy_acc = energy_acc + 64'(mag) * 64'(mag);
    if (count_acc > 0 && neg != prev_neg) cross_acc++;
    prev_neg = neg;
    if (32'(mag) > peak_acc) peak_acc = 32'(mag);
    count_acc++;
    n_eff = 32'(frame_len_cfg);
    if (n_eff < 1) n_eff = 1;
    if (n_eff > MAX_LEN) n_eff = MAX_LEN;
    if (count_acc >= n_eff) begin
      r.mean = MEAN_W'(energy_acc / 64'(count_acc));
      r.rate = RATE_W'((64'(cross_acc) << 16) / 64'(count_acc));
      r.peak = PEAK_W'(peak_acc);
      expected_frames.push_back(r);
      energy_acc = '0;
      cross_acc = 0;
      prev_neg = 1'b0;
      peak_acc = 0;
      count_acc = 0;
    end
  endtask

  task automatic check_frame();
    frame_stats_t want;
    if (expected_frames.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected frame result: mean %0d rate %0d peak %0d",
                 mean_energy, crossing_rate, peak_level);
    end else begin
      want = expected_frames.pop_front();
      frames_checked++;
      if (want.mean !== mean_energy || want.rate !== crossing_rate ||
          want.peak !== peak_level) begin
        errors++;
        if (errors <= 10)
          $display("frame %0d: expected mean %0d rate %0d peak %0d, got %0d %0d %0d",
                   frames_checked, want.mean, want.rate, want.peak,
                   mean_energy, crossing_rate, peak_level);
      end
    end
  endtask

  // monitor and frame model
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      frame_len_cfg = LEN_W'(FRAME_LEN_RESET);
      energy_acc = '0;
      cross_acc = 0;
      prev_neg = 1'b0;
      peak_acc = 0;
      count_acc = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        frame_len_cfg = cfg_data;
        len_writes++;
      end
      if (out_valid && !out_stall) check_frame();
      if (in_valid && !in_stall) begin
        words_taken++;
        fold_word(raw_word);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_energy_zcr_peak_top: mismatch");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_left <= 0;
    end else if (!in_valid || in_taken) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (send_gaps && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        idle_left <= $urandom_range(0, 4);
      end else if (pending_words.size() > 0) begin
        raw_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [RAW_W-1:0] pack_word(input logic [15:0] smp);
    logic [1:0]  top;
    logic [13:0] low;
    top = 2'($urandom);
    low = 14'($urandom);
    return {top, smp, low};
  endfunction

  function automatic logic [RAW_W-1:0] random_word();
    logic [15:0] smp;
    smp = 16'($urandom);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: smp = 16'($urandom_range(0, 6) - 3);
      2: begin
        case ($urandom_range(0, 4))
          0: smp = 16'h8000;
          1: smp = 16'h7FFF;
          2: smp = 16'h8001;
          3: smp = 16'h0000;
          default: smp = 16'hFFFF;
        endcase
      end
      default: ;
    endcase
    return pack_word(smp);
  endfunction

  task automatic write_frame_len(input int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= LEN_W'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int lens[10];
    int counts[10];
    lens   = '{1, 3, 7, 16, 1024, 5, 33, 100, 2047, 6};
    counts = '{40, 45, 49, 64, 30, 40, 99, 100, 250, 60};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // partial frame at the reset length, then cut short by a length change
    for (int i = 0; i < 10; i++) pending_words.push_back(random_word());
    settle();

    // length 0: every word is a frame, field extremes
    write_frame_len(0);
    pending_words.push_back(32'h0000_0000);
    pending_words.push_back(32'hFFFF_FFFF);
    pending_words.push_back(32'h7FFF_FFFF);
    pending_words.push_back(32'h8000_0000);
    pending_words.push_back(32'h1FFF_C000);
    pending_words.push_back(32'h2000_0000);
    pending_words.push_back(32'hE000_3FFF);
    pending_words.push_back(pack_word(16'h8001));
    pending_words.push_back(pack_word(16'h0001));
    pending_words.push_back(pack_word(16'hC000));
    settle();

    // length 2: sign change pairs, zero counts as positive
    write_frame_len(2);
    pending_words.push_back(pack_word(16'h0100));
    pending_words.push_back(pack_word(16'hFF00));
    pending_words.push_back(pack_word(16'hFF00));
    pending_words.push_back(pack_word(16'h0100));
    pending_words.push_back(pack_word(16'h0000));
    pending_words.push_back(pack_word(16'hFFFF));
    pending_words.push_back(pack_word(16'hFFFF));
    pending_words.push_back(pack_word(16'h0000));
    pending_words.push_back(pack_word(16'h7FFF));
    pending_words.push_back(pack_word(16'h0001));
    pending_words.push_back(pack_word(16'h8000));
    pending_words.push_back(pack_word(16'h8000));
    settle();

    for (int p = 0; p < 10; p++) begin
      write_frame_len(lens[p]);
      send_gaps = (p == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      recv_gaps = (p == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (p == 0) hold_asked++;
      for (int i = 0; i < counts[p]; i++) begin
        if (lens[p] > MAX_LEN)
          pending_words.push_back(pack_word((i % 2) ? 16'h7FFF : 16'h8000));
        else
          pending_words.push_back(random_word());
      end
      settle();
    end

    if (expected_frames.size() != 0) errors++;
    $display("sent %0d words over %0d frame length settings, checked %0d frames",
             words_taken, len_writes + 1, frames_checked);
    $display("lengths included 0, 1, 1024 and 2047, with changes inside frames");
    if (errors == 0) begin
      $display("frame_energy_zcr_peak_top: match");
    end else begin
      $display("frame_energy_zcr_peak_top: mismatch");
    end
    $finish;
  end

endmodule
